// ===== hw/rtl/tnau_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tree node address unit package
// Word types for both channels, the address constants and the byte table
// used to build radio pipe addresses.
// ---------------------------------------------------------------------------
package tnau_pkg;

    // Field widths.
    localparam int unsigned NodeWidth  = 12;
    localparam int unsigned DigitWidth = 3;
    localparam int unsigned AddrWidth  = 40;

    // Fill byte for unused address bytes.
    localparam logic [7:0] FillByte = 8'hCC;

    // Addresses that are valid although they hold a zero digit.
    localparam logic [NodeWidth-1:0] SpecialNodeA = 12'o0100;
    localparam logic [NodeWidth-1:0] SpecialNodeB = 12'o0010;

    // Lowest and highest digit value allowed in a tree address.
    localparam logic [DigitWidth-1:0] DigitMin = 3'd1;
    localparam logic [DigitWidth-1:0] DigitMax = 3'd5;

    // Input word.
    typedef struct packed {
        logic [NodeWidth-1:0]  tree_addr;
        logic [DigitWidth-1:0] pipe_number;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic                  address_valid;
        logic [NodeWidth-1:0]  up_node;
        logic [DigitWidth-1:0] up_pipe;
        logic [AddrWidth-1:0]  pipe_address;
    } t_out_word;

    // Translate a digit or pipe value to its address byte; seven has no entry.
    function automatic logic [7:0] xlat_byte(input logic [DigitWidth-1:0] v);
        logic [7:0] b;
        case (v)
            3'd0:    b = 8'hC3;
            3'd1:    b = 8'h3C;
            3'd2:    b = 8'h33;
            3'd3:    b = 8'hCE;
            3'd4:    b = 8'h3E;
            3'd5:    b = 8'hE3;
            3'd6:    b = 8'hEC;
            default: b = FillByte;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/tnau_decode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tree node address decoder
// Combinational check of a node address, split into parent node and pipe,
// and assembly of the 40-bit radio pipe address.
// ---------------------------------------------------------------------------
module tnau_decode (
    input  tnau_pkg::t_in_word  i_word,
    output tnau_pkg::t_out_word o_word
);
    import tnau_pkg::*;

    logic [DigitWidth-1:0] digit [4];
    logic [2:0]            num_digits;
    logic                  digits_ok;
    logic [7:0]            addr_byte [5];

    // Split the address into its four octal digits.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            digit[k] = i_word.tree_addr[DigitWidth*k +: DigitWidth];
        end
    end

    // Count significant digits up to the most significant nonzero one.
    always_comb begin
        if (digit[3] != '0) begin
            num_digits = 3'd4;
        end else if (digit[2] != '0) begin
            num_digits = 3'd3;
        end else if (digit[1] != '0) begin
            num_digits = 3'd2;
        end else if (digit[0] != '0) begin
            num_digits = 3'd1;
        end else begin
            num_digits = 3'd0;
        end
    end

    // Every significant digit must lie in the allowed range.
    always_comb begin
        digits_ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if ((3'(k) < num_digits) &&
                ((digit[k] < DigitMin) || (digit[k] > DigitMax))) begin
                digits_ok = 1'b0;
            end
        end
    end

    // Address bytes: pipe byte at the bottom, one byte per significant digit.
    always_comb begin
        addr_byte[0] = xlat_byte(i_word.pipe_number);
        for (int k = 0; k < 4; k++) begin
            addr_byte[k+1] = (3'(k) < num_digits) ? xlat_byte(digit[k]) : FillByte;
        end
    end

    // Parent pipe is the top digit, parent node what lies below it.
    always_comb begin
        o_word.address_valid = digits_ok ||
                               (i_word.tree_addr == SpecialNodeA) ||
                               (i_word.tree_addr == SpecialNodeB);
        case (num_digits)
            3'd4: begin
                o_word.up_pipe = digit[3];
                o_word.up_node = {3'd0, i_word.tree_addr[8:0]};
            end
            3'd3: begin
                o_word.up_pipe = digit[2];
                o_word.up_node = {6'd0, i_word.tree_addr[5:0]};
            end
            3'd2: begin
                o_word.up_pipe = digit[1];
                o_word.up_node = {9'd0, i_word.tree_addr[2:0]};
            end
            3'd1: begin
                o_word.up_pipe = digit[0];
                o_word.up_node = '0;
            end
            default: begin
                o_word.up_pipe = '0;
                o_word.up_node = '0;
            end
        endcase
        o_word.pipe_address = {addr_byte[4], addr_byte[3], addr_byte[2],
                               addr_byte[1], addr_byte[0]};
    end

endmodule

// ===== hw/rtl/tree_node_address_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tree node address unit
// Validates an octal tree node address, finds its parent node and pipe, and
// builds the radio pipe address for a given pipe of that node.
// ---------------------------------------------------------------------------
// One word is taken per cycle while o_in_stall is low. An input register feeds
// the decoder, whose output is caught in a result register, so the result
// reaches o_out_word once the word has passed through both registers.
// The input register loads whenever it is empty or its word moves on, so a
// new word can enter in every cycle while the downstream side keeps taking
// results. A stalled result holds the input register once that is full, which
// then raises o_in_stall; at most two words are held inside.
module tree_node_address_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tnau_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tnau_pkg::t_out_word o_out_word
);
    import tnau_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word dec_word;
    logic      out_open;
    logic      in_open;

    // The result register can load when empty or when its word is taken.
    assign out_open   = !r_out_valid || !i_out_stall;
    assign in_open    = !r_in_valid || out_open;
    assign o_in_stall = !in_open;

    // Valid flags for both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_open) begin
                r_in_valid <= i_in_valid;
            end
            if (out_open) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_open && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (out_open && r_in_valid) begin
            r_out_word <= dec_word;
        end
    end

    // Decode between the two registers.
    tnau_decode u_decode (
        .i_word (r_in_word),
        .o_word (dec_word)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== test/tree_node_address_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tree node address unit testbench
// Sends octal node addresses with pipe numbers through the input channel and
// checks every result word field by field against a predictor of the address
// decoding. A directed part covers the corner addresses, a random part covers
// well-formed tree addresses, special addresses and raw noise, and a pressure
// part holds off the result side long enough to stall the input.
// ---------------------------------------------------------------------------
module tree_node_address_unit_tb;

    import tnau_pkg::*;

    // Run control.
    localparam int unsigned IdlePercent   = 9;
    localparam int unsigned CycleLimit    = 400000;
    localparam int unsigned HoldCycles    = 300;
    localparam int unsigned DrainCycles   = 8;
    localparam int unsigned RandomWords   = 1300;
    localparam int unsigned QuietWords    = 300;
    localparam int unsigned PressureWords = 128;

    // Address byte for each digit or pipe value 0..6, value 0 in the low byte.
    localparam logic [55:0] RadioByteTable = 56'hEC_E3_3E_CE_33_3C_C3;
    localparam int unsigned MaxDigits = 4;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Words still owed by the block, oldest first.
    t_out_word pending_results[$];

    int unsigned error_count = 0;
    int unsigned checked_count = 0;
    int unsigned valid_seen = 0;
    int unsigned cycle_count = 0;
    bit          idling_on = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;

    tree_node_address_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    // Clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Translate one digit or pipe value to its radio address byte.
    function automatic logic [7:0] radio_byte(input logic [DigitWidth-1:0] v);
        if (v == 3'd7) begin
            return FillByte;
        end
        return RadioByteTable[8*v +: 8];
    endfunction

    // Work out the decoded tree address for one input word.
    function automatic t_out_word decode_tree_address(input t_in_word w);
        t_out_word            r;
        logic [NodeWidth-1:0] node;
        logic [DigitWidth-1:0] d;
        int unsigned          ndig;
        int unsigned          k;
        node = w.tree_addr;
        ndig = 0;
        for (k = 0; k < MaxDigits; k++) begin
            if (node[3*k +: 3] != 3'd0) begin
                ndig = k + 1;
            end
        end
        r.address_valid = 1'b1;
        r.up_node = '0;
        r.up_pipe = '0;
        r.pipe_address = {5{FillByte}};
        r.pipe_address[7:0] = radio_byte(w.pipe_number);
        for (k = 0; k < ndig; k++) begin
            d = node[3*k +: 3];
            if (d < DigitMin || d > DigitMax) begin
                r.address_valid = 1'b0;
            end
            r.pipe_address[8*(k+1) +: 8] = radio_byte(d);
        end
        // The two special addresses pass although they hold zero digits.
        if (node == SpecialNodeA || node == SpecialNodeB) begin
            r.address_valid = 1'b1;
        end
        if (ndig > 0) begin
            r.up_pipe = node[3*(ndig-1) +: 3];
            r.up_node = node & ((12'd1 << (3*(ndig-1))) - 12'd1);
        end
        return r;
    endfunction

    // Offer one word, with random idle cycles ahead of it, until it is taken.
    task automatic send_word(input t_in_word w);
        while (idling_on && $urandom_range(0, 99) < IdlePercent) begin
            in_valid <= 1'b0;
            in_word <= t_in_word'(15'($urandom));
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        pending_results.push_back(decode_tree_address(w));
    endtask

    function automatic t_in_word make_word(input int unsigned node, input int unsigned pipe);
        t_in_word w;
        w.tree_addr = node[NodeWidth-1:0];
        w.pipe_number = pipe[DigitWidth-1:0];
        return w;
    endfunction

    // A tree address with 0..4 digits, each digit in the allowed range.
    function automatic logic [NodeWidth-1:0] well_formed_node();
        logic [NodeWidth-1:0] node;
        int unsigned          ndig;
        int unsigned          k;
        node = '0;
        ndig = $urandom_range(0, MaxDigits);
        for (k = 0; k < ndig; k++) begin
            node[3*k +: 3] = 3'($urandom_range(DigitMin, DigitMax));
        end
        return node;
    endfunction

    // One random word: mostly well-formed, some special, some broken or noise.
    function automatic t_in_word random_word();
        t_in_word             w;
        logic [NodeWidth-1:0] node;
        int unsigned          pick;
        int unsigned          k;
        pick = $urandom_range(0, 99);
        node = well_formed_node();
        if (pick < 6) begin
            node = pick[0] ? SpecialNodeA : SpecialNodeB;
        end else if (pick < 25) begin
            // Break one digit of a well-formed address.
            k = $urandom_range(0, MaxDigits - 1);
            node[3*k +: 3] = ($urandom_range(0, 2) == 0) ? 3'd0
                                                         : 3'($urandom_range(6, 7));
        end else if (pick < 40) begin
            node = 12'($urandom);
        end
        w.tree_addr = node;
        w.pipe_number = 3'($urandom);
        return w;
    endfunction

    // Result side: check each taken word, then pick the next stall value.
    initial begin
        t_out_word want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no word pending: %h", out_word);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (want.address_valid) begin
                        valid_seen++;
                    end
                    if (out_word.address_valid !== want.address_valid) begin
                        $error("address_valid: expected %0d, actual %0d",
                               want.address_valid, out_word.address_valid);
                        error_count++;
                    end
                    if (out_word.up_node !== want.up_node) begin
                        $error("up_node: expected %o, actual %o",
                               want.up_node, out_word.up_node);
                        error_count++;
                    end
                    if (out_word.up_pipe !== want.up_pipe) begin
                        $error("up_pipe: expected %0d, actual %0d",
                               want.up_pipe, out_word.up_pipe);
                        error_count++;
                    end
                    if (out_word.pipe_address !== want.pipe_address) begin
                        $error("pipe_address: expected %h, actual %h",
                               want.pipe_address, out_word.pipe_address);
                        error_count++;
                    end
                end
            end
            // A long hold-off is counted here once the pressure test asks for it.
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= idling_on && ($urandom_range(0, 99) < IdlePercent);
            end
        end
    end

    // Watchdog.
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CycleLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Corner addresses: node zero, all digits, special addresses, digit and pipe seven.
    task automatic test_corner_addresses();
        send_word(make_word(0, 0));
        send_word(make_word(0, 7));
        send_word(make_word('o7777, 6));
        send_word(make_word('o0100, 1));
        send_word(make_word('o0010, 2));
        send_word(make_word('o0001, 3));
        send_word(make_word('o5555, 4));
        send_word(make_word('o1234, 5));
        send_word(make_word('o0007, 7));
        send_word(make_word('o0070, 0));
        send_word(make_word('o0700, 1));
        send_word(make_word('o7000, 2));
        send_word(make_word('o0101, 3));
        send_word(make_word('o0016, 4));
        send_word(make_word('o1000, 5));
        send_word(make_word('o0110, 6));
        send_word(make_word('o4321, 7));
        send_word(make_word('o0005, 0));
        send_word(make_word('o0055, 1));
        send_word(make_word('o0555, 2));
        send_word(make_word('o6000, 3));
        send_word(make_word('o0200, 4));
        send_word(make_word('o0155, 5));
    endtask

    // Random words with idling on both sides.
    task automatic test_random_addresses();
        int unsigned n;
        for (n = 0; n < RandomWords; n++) begin
            send_word(random_word());
        end
    endtask

    // Random words back to back with no idling on either side.
    task automatic test_full_rate();
        int unsigned n;
        idling_on = 1'b0;
        for (n = 0; n < QuietWords; n++) begin
            send_word(random_word());
        end
        idling_on = 1'b1;
    endtask

    // Result side holds off while words keep coming, so the input stalls.
    task automatic test_result_hold_off();
        int unsigned n;
        hold_request = 1'b1;
        for (n = 0; n < PressureWords; n++) begin
            send_word(random_word());
        end
    endtask

    // Sequence of tests.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_addresses();
        test_random_addresses();
        test_full_rate();
        test_result_hold_off();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        $display("Checked %0d result words, %0d of them valid tree addresses.",
                 checked_count, valid_seen);
        $display("Covered corner addresses, random traffic, full rate and a long hold-off.");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tnau_pkg.sv
hw/rtl/tnau_decode.sv
hw/rtl/tree_node_address_unit.sv
test/tree_node_address_unit_tb.sv
